[src/dcmre_pkg.sv]
// Shared types and constants for the dirty cell map rectangle extractor.
// No dependencies; the channel interfaces, the core and both testbench files import this package.
`default_nettype none

package dcmre_pkg;

  // Field widths of the request and response words
  localparam int OP_W       = 3;
  localparam int COORD_W    = 7;
  localparam int RECT_LO_W  = 6;
  localparam int RECT_HI_W  = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b1;

  // Reset value of both grid size registers
  localparam logic [CFG_DATA_W-1:0] GRID_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_MARK_RECT   = 3'd0,
    OP_POP_RECT    = 3'd1,
    OP_CLEAR_MAP   = 3'd2,
    OP_MARK_CELL   = 3'd3,
    OP_UNMARK_CELL = 3'd4,
    OP_QUERY_CELL  = 3'd5
  } op_t;

endpackage

`default_nettype wire

[src/dcmre_ifs.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on dcmre_pkg for the op type and field widths.
`default_nettype none

interface dcmre_in_if import dcmre_pkg::*; ();
  logic                valid;
  logic                ready;
  op_t                 op;
  logic [COORD_W-1:0]  first_col;
  logic [COORD_W-1:0]  first_row;
  logic [COORD_W-1:0]  end_col;
  logic [COORD_W-1:0]  end_row;

  modport source (output valid, op, first_col, first_row, end_col, end_row, input ready);
  modport sink   (input valid, op, first_col, first_row, end_col, end_row, output ready);
endinterface

interface dcmre_out_if import dcmre_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic                 cell_on;
  logic [RECT_LO_W-1:0] rect_first_col;
  logic [RECT_LO_W-1:0] rect_first_row;
  logic [RECT_HI_W-1:0] rect_end_col;
  logic [RECT_HI_W-1:0] rect_end_row;

  modport source (output valid, found, cell_on, rect_first_col, rect_first_row,
                  rect_end_col, rect_end_row, input ready);
  modport sink   (input valid, found, cell_on, rect_first_col, rect_first_row,
                  rect_end_col, rect_end_row, output ready);
endinterface

`default_nettype wire

[src/dcmre_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dcmre_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/dirty_cell_map_rect_extract_core.sv]
// Dirty cell map with rectangle extraction. The map holds one row of MAX_COLS bits per
// grid row in a RAM with a registered read; a row flag per entry (cleared at reset, by a
// clear-map word and by any configuration write) makes unwritten rows read as empty, so
// there is no clearing pass. Words are handled one at a time. Mark rectangle and pop
// stream the rows through the RAM at one row per cycle (read one row while writing back
// the previous one); pop stops early once the rectangle ends below. A finished result
// waits in the response register while the next request word is taken; a result that
// is still not taken stalls the following one.
// Depends on dcmre_pkg, dcmre_ifs and dcmre_ram.
`default_nettype none

module dirty_cell_map_rect_extract_core import dcmre_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  dcmre_in_if.sink              req,
  dcmre_out_if.source           rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W = $clog2(MAX_ROWS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CELL,
    S_FIN
  } state_t;

  state_t state;

  // Configuration and map bookkeeping
  logic [CFG_DATA_W-1:0] grid_cols;
  logic [CFG_DATA_W-1:0] grid_rows;
  logic [MAX_ROWS-1:0]   row_valid;

  // Latched request
  op_t                cur_op;
  logic [COORD_W-1:0] col_lo;
  logic [COORD_W-1:0] col_hi;

  // Row stream
  logic [CNT_W-1:0] rd_addr;
  logic [CNT_W-1:0] lim;
  logic             d_vld;
  logic [RW-1:0]    d_row;
  logic             d_rowv;

  // Pop tracking
  logic              hit;
  logic              halt;
  logic [MAX_COLS-1:0] run_mask;
  logic [MAX_COLS-1:0] low_mask;
  logic [MAX_COLS:0]   end_mask;
  logic [RW-1:0]       rect_row;
  logic [CNT_W-1:0]    rect_row_end;
  logic                cell_on;

  // Derived values
  logic [COORD_W-1:0]  eff_cols;
  logic [CNT_W-1:0]    eff_rows;
  logic [CNT_W-1:0]    er_clip;
  logic [COORD_W-1:0]  ec_clip;
  logic                on_grid;
  logic                accept;
  logic                issue;
  logic [MAX_COLS-1:0] cols_mask;
  logic [MAX_COLS-1:0] rect_mask;
  logic [MAX_COLS-1:0] cell_mask;
  logic [MAX_COLS-1:0] ram_q;
  logic [MAX_COLS-1:0] row_data;
  logic [MAX_COLS-1:0] pop_data;
  logic [MAX_COLS-1:0] lowbit_c;
  logic [MAX_COLS:0]   sum_c;
  logic [MAX_COLS-1:0] run_c;
  logic [MAX_COLS:0]   endb_c;
  logic [MAX_COLS-1:0] left_mask;
  logic                ext_ok;
  logic                pop_first;
  logic                pop_ext;
  logic                mem_we;
  logic [RW-1:0]       waddr;
  logic [MAX_COLS-1:0] wdata;
  logic [RW-1:0]       raddr;
  logic                rd_issue;
  logic [COORD_W-1:0]  start_col_enc;
  logic [COORD_W-1:0]  end_col_enc;

  // Clip grid size to the storage
  assign eff_cols = (32'(grid_cols) > MAX_COLS) ? COORD_W'(MAX_COLS) : grid_cols;
  assign eff_rows = (32'(grid_rows) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : CNT_W'(grid_rows);

  // Clip request coordinates
  assign er_clip = (32'(req.end_row) > 32'(eff_rows)) ? eff_rows : CNT_W'(req.end_row);
  assign ec_clip = (col_hi > eff_cols) ? eff_cols : col_hi;
  assign on_grid = (req.first_col < eff_cols) && (32'(req.first_row) < 32'(eff_rows));

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // Column masks for the grid, the rectangle and the single cell
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      cols_mask[i] = COORD_W'(i) < eff_cols;
      rect_mask[i] = (COORD_W'(i) >= col_lo) && (COORD_W'(i) < ec_clip);
      cell_mask[i] = COORD_W'(i) == col_lo;
    end
  end

  // Row returned from the RAM; unwritten rows read as empty
  assign row_data = d_rowv ? ram_q : '0;
  assign pop_data = row_data & cols_mask;

  // Isolate the first marked run: adding the lowest set bit ripples through the run
  assign lowbit_c = pop_data & ((~pop_data) + MAX_COLS'(1));
  assign sum_c    = {1'b0, pop_data} + {1'b0, lowbit_c};
  assign run_c    = pop_data & ~sum_c[MAX_COLS-1:0];
  assign endb_c   = sum_c & ~{1'b0, pop_data};

  // A lower row extends the rectangle when its run matches and both neighbors are clear
  assign left_mask = low_mask >> 1;
  assign ext_ok    = ((pop_data & run_mask) == run_mask) &&
                     ((pop_data & left_mask) == '0) &&
                     (({1'b0, pop_data} & end_mask) == '0);

  assign issue     = (state == S_SCAN) && (rd_addr < lim) && !halt;
  assign pop_first = (state == S_SCAN) && (cur_op == OP_POP_RECT) && d_vld && !hit &&
                     (pop_data != '0);
  assign pop_ext   = (state == S_SCAN) && (cur_op == OP_POP_RECT) && d_vld && hit && !halt;

  // Read address: cell access at accept, row stream in scan
  always_comb begin
    rd_issue = 1'b0;
    raddr    = RW'(rd_addr);
    if (issue) begin
      rd_issue = 1'b1;
    end else if (accept && on_grid &&
                 (req.op == OP_MARK_CELL || req.op == OP_UNMARK_CELL ||
                  req.op == OP_QUERY_CELL)) begin
      rd_issue = 1'b1;
      raddr    = RW'(req.first_row);
    end
  end

  // Write back the modified row
  always_comb begin
    mem_we = 1'b0;
    waddr  = d_row;
    wdata  = row_data;
    unique case (state)
      S_SCAN: begin
        if (d_vld && cur_op == OP_MARK_RECT) begin
          mem_we = 1'b1;
          wdata  = row_data | rect_mask;
        end else if (pop_first) begin
          mem_we = 1'b1;
          wdata  = row_data & ~run_c;
        end else if (pop_ext && ext_ok) begin
          mem_we = 1'b1;
          wdata  = row_data & ~run_mask;
        end
      end
      S_CELL: begin
        if (cur_op == OP_MARK_CELL) begin
          mem_we = 1'b1;
          wdata  = row_data | cell_mask;
        end else if (cur_op == OP_UNMARK_CELL) begin
          mem_we = 1'b1;
          wdata  = row_data & ~cell_mask;
        end
      end
      default: ;
    endcase
  end

  // Encode the one-hot start and end column positions
  always_comb begin
    start_col_enc = '0;
    end_col_enc   = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (low_mask[i]) start_col_enc = start_col_enc | COORD_W'(i);
    end
    for (int i = 0; i <= MAX_COLS; i++) begin
      if (end_mask[i]) end_col_enc = end_col_enc | COORD_W'(i);
    end
  end

  dcmre_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Sequencer, bookkeeping and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      grid_cols <= GRID_RESET;
      grid_rows <= GRID_RESET;
      row_valid <= '0;
      d_vld     <= 1'b0;
      hit       <= 1'b0;
      halt      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      d_vld  <= rd_issue;
      d_row  <= raddr;
      d_rowv <= row_valid[raddr];

      if (mem_we) begin
        row_valid[waddr] <= 1'b1;
      end

      // Drop the response word once taken, unless the next one loads now
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_op  <= req.op;
            col_lo  <= req.first_col;
            col_hi  <= req.end_col;
            hit     <= 1'b0;
            halt    <= 1'b0;
            cell_on <= 1'b0;
            unique case (req.op)
              OP_MARK_RECT: begin
                if (32'(req.first_row) < 32'(er_clip)) begin
                  rd_addr <= CNT_W'(req.first_row);
                  lim     <= er_clip;
                  state   <= S_SCAN;
                end else begin
                  state <= S_FIN;
                end
              end
              OP_POP_RECT: begin
                rd_addr <= '0;
                lim     <= eff_rows;
                state   <= S_SCAN;
              end
              OP_CLEAR_MAP: begin
                row_valid <= '0;
                state     <= S_FIN;
              end
              OP_MARK_CELL, OP_UNMARK_CELL, OP_QUERY_CELL: begin
                state <= on_grid ? S_CELL : S_FIN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_addr <= rd_addr + CNT_W'(1);
          end
          if (pop_first) begin
            hit          <= 1'b1;
            run_mask     <= run_c;
            low_mask     <= lowbit_c;
            end_mask     <= endb_c;
            rect_row     <= d_row;
            rect_row_end <= CNT_W'(d_row) + CNT_W'(1);
          end else if (pop_ext) begin
            if (ext_ok) begin
              rect_row_end <= CNT_W'(d_row) + CNT_W'(1);
            end else begin
              halt <= 1'b1;
            end
          end
          if (!issue && !d_vld) begin
            state <= S_FIN;
          end
        end
        S_CELL: begin
          if (cur_op == OP_QUERY_CELL) begin
            cell_on <= |(row_data & cell_mask);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid          <= 1'b1;
            rsp.found          <= hit;
            rsp.cell_on        <= cell_on;
            rsp.rect_first_col <= hit ? RECT_LO_W'(start_col_enc) : '0;
            rsp.rect_first_row <= hit ? RECT_LO_W'(rect_row) : '0;
            rsp.rect_end_col   <= hit ? RECT_HI_W'(end_col_enc) : '0;
            rsp.rect_end_row   <= hit ? RECT_HI_W'(rect_row_end) : '0;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Any configuration write resizes the grid and empties the map
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_COLS: grid_cols <= cfg_data;
          CFG_GRID_ROWS: grid_rows <= cfg_data;
          default: ;
        endcase
        row_valid <= '0;
      end
    end
  end

  // RAM writes come only from the row stream or a cell update
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SCAN || state == S_CELL))
    else $error("map write outside scan or cell update");

  // The row stream never runs past its limit
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (rd_addr <= lim))
    else $error("row stream passed its limit");

  // Back-to-back stream writes go to distinct rows, so no forwarding is needed
  assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == S_SCAN && $past(mem_we) && $past(state) == S_SCAN)
      |-> (waddr != $past(waddr)))
    else $error("stream wrote the same row twice in a row");

  // A popped rectangle is never empty
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |->
      (rsp.rect_end_col > 7'(rsp.rect_first_col) &&
       rsp.rect_end_row > 7'(rsp.rect_first_row)))
    else $error("popped rectangle is empty");

  // An accepted word always leaves idle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted word did not start");

endmodule

`default_nettype wire

[verif/dcmre_checker.sv]
`timescale 1ns / 1ps
// Checker for the dirty cell map rectangle extractor: watches the request, response
// and configuration ports, keeps its own copy of the cell map and compares each result.
// Depends on dcmre_pkg and the channel interfaces in dcmre_ifs.

module dcmre_checker import dcmre_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  dcmre_in_if                   req,
  dcmre_out_if                  rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    words_pending
);

  localparam int MAP_COLS = 64;
  localparam int MAP_ROWS = 64;

  typedef struct packed {
    logic                 found;
    logic                 cell_on;
    logic [RECT_LO_W-1:0] rect_first_col;
    logic [RECT_LO_W-1:0] rect_first_row;
    logic [RECT_HI_W-1:0] rect_end_col;
    logic [RECT_HI_W-1:0] rect_end_row;
  } map_answer_t;

  logic [MAP_COLS-1:0]   cell_rows [MAP_ROWS];
  logic [CFG_DATA_W-1:0] cols_reg;
  logic [CFG_DATA_W-1:0] rows_reg;
  map_answer_t           answers_due [$];
  map_answer_t           oldest;

  function automatic int cols_in_use();
    return (cols_reg > MAP_COLS) ? MAP_COLS : int'(cols_reg);
  endfunction

  function automatic int rows_in_use();
    return (rows_reg > MAP_ROWS) ? MAP_ROWS : int'(rows_reg);
  endfunction

  function automatic void clear_map();
    foreach (cell_rows[i]) cell_rows[i] = '0;
  endfunction

  // Count marked cells from col rightward, stopping at the grid edge
  function automatic int run_right(int col, int row, int cols);
    int n;
    n = 0;
    while (col + n < cols && cell_rows[row][col + n]) n++;
    return n;
  endfunction

  // Find the first marked cell, grow the rectangle downward, unmark it
  function automatic map_answer_t cut_first_rect();
    map_answer_t ans;
    int cols, rows, w, h;
    ans = '0;
    cols = cols_in_use();
    rows = rows_in_use();
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (cell_rows[r][c]) begin
          w = run_right(c, r, cols);
          for (int i = 0; i < w; i++) cell_rows[r][c + i] = 1'b0;
          h = 1;
          while (r + h < rows) begin
            // stop where the cell left of the start is marked or the run differs
            if (c > 0 && cell_rows[r + h][c - 1]) break;
            if (run_right(c, r + h, cols) != w) break;
            for (int i = 0; i < w; i++) cell_rows[r + h][c + i] = 1'b0;
            h++;
          end
          ans.found          = 1'b1;
          ans.rect_first_col = RECT_LO_W'(c);
          ans.rect_first_row = RECT_LO_W'(r);
          ans.rect_end_col   = RECT_HI_W'(c + w);
          ans.rect_end_row   = RECT_HI_W'(r + h);
          return ans;
        end
      end
    end
    return ans;
  endfunction

  // Apply one request word to the map and return the answer it should produce
  function automatic map_answer_t apply_map_word(logic [OP_W-1:0] op,
                                                 logic [COORD_W-1:0] fc, fr, ec, er);
    map_answer_t ans;
    int cols, rows, last_c, last_r;
    bit on_grid;
    ans = '0;
    cols = cols_in_use();
    rows = rows_in_use();
    on_grid = (fc < cols) && (fr < rows);
    case (op)
      OP_MARK_RECT: begin
        last_c = (ec > cols) ? cols : int'(ec);
        last_r = (er > rows) ? rows : int'(er);
        for (int r = fr; r < last_r; r++)
          for (int c = fc; c < last_c; c++) cell_rows[r][c] = 1'b1;
      end
      OP_POP_RECT:    ans = cut_first_rect();
      OP_CLEAR_MAP:   clear_map();
      OP_MARK_CELL:   if (on_grid) cell_rows[fr][fc] = 1'b1;
      OP_UNMARK_CELL: if (on_grid) cell_rows[fr][fc] = 1'b0;
      OP_QUERY_CELL:  if (on_grid) ans.cell_on = cell_rows[fr][fc];
      default: ;
    endcase
    return ans;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count    = 0;
    words_pending = 0;
    cols_reg      = GRID_RESET;
    rows_reg      = GRID_RESET;
    clear_map();
  end

  always @(posedge clk) begin
    if (rst) begin
      cols_reg = GRID_RESET;
      rows_reg = GRID_RESET;
      clear_map();
      answers_due.delete();
    end else begin
      // Any register write also wipes the map
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_COLS) cols_reg = cfg_data;
        else if (cfg_index == CFG_GRID_ROWS) rows_reg = cfg_data;
        clear_map();
      end
      if (req.valid && req.ready)
        answers_due.push_back(apply_map_word(req.op, req.first_col, req.first_row,
                                             req.end_col, req.end_row));
      if (rsp.valid && rsp.ready) begin
        if (answers_due.size() == 0) begin
          $error("result word with no request outstanding");
          fail_count++;
        end else begin
          oldest = answers_due.pop_front();
          check_field("found", oldest.found, rsp.found);
          check_field("cell_on", oldest.cell_on, rsp.cell_on);
          check_field("rect_first_col", oldest.rect_first_col, rsp.rect_first_col);
          check_field("rect_first_row", oldest.rect_first_row, rsp.rect_first_row);
          check_field("rect_end_col", oldest.rect_end_col, rsp.rect_end_col);
          check_field("rect_end_row", oldest.rect_end_row, rsp.rect_end_row);
        end
      end
    end
    words_pending = answers_due.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Top of the dirty cell map rectangle extractor testbench: clock, reset, grid settings,
// request words and response back-pressure. Depends on dcmre_pkg, dcmre_ifs, the core
// and dcmre_checker, which does all prediction and comparison.

module tb_top;
  import dcmre_pkg::*;

  localparam int MAX_GRID         = 64;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES      = 80;
  localparam int N_PHASES         = 11;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    words_pending;
  int                    cycle_count;
  int                    items_sent;
  int                    grid_c;
  int                    grid_r;
  bit                    steady;
  bit                    long_hold;

  // Grid settings per phase, with the number of words sent under each
  int phase_cols  [N_PHASES] = '{64, 8, 0, 5, 1, 127, 64, 3, 100, 16, 64};
  int phase_rows  [N_PHASES] = '{64, 6, 7, 0, 1, 127, 2, 64, 10, 65, 33};
  int phase_items [N_PHASES] = '{140, 100, 15, 15, 40, 120, 80, 80, 80, 100, 130};

  dcmre_in_if  req_ch ();
  dcmre_out_if rsp_ch ();

  dirty_cell_map_rect_extract_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dcmre_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, some short, a few long; none in steady stretches
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(int dim);
    if ($urandom_range(0, 99) < 12) return COORD_W'($urandom_range(0, 127));
    return COORD_W'($urandom_range(0, dim));
  endfunction

  function automatic logic [COORD_W-1:0] pick_end(logic [COORD_W-1:0] start, int dim);
    if ($urandom_range(0, 99) < 10) return COORD_W'($urandom_range(0, 127));
    return COORD_W'(start + $urandom_range(0, dim / 3 + 2));
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(op_t op, logic [COORD_W-1:0] fc, fr, ec, er);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.first_col <= fc;
    req_ch.first_row <= fr;
    req_ch.end_col   <= ec;
    req_ch.end_row   <= er;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_rect();
    logic [COORD_W-1:0] fc, fr;
    fc = pick_coord(grid_c);
    fr = pick_coord(grid_r);
    send_word(OP_MARK_RECT, fc, fr, pick_end(fc, grid_c), pick_end(fr, grid_r));
  endtask

  task automatic send_cell_word();
    op_t op;
    case ($urandom_range(0, 2))
      0:       op = OP_MARK_CELL;
      1:       op = OP_UNMARK_CELL;
      default: op = OP_QUERY_CELL;
    endcase
    send_word(op, pick_coord(grid_c), pick_coord(grid_r),
              COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic send_random_word();
    int roll;
    op_t op;
    roll = $urandom_range(0, 99);
    if (roll < 25) send_rect();
    else if (roll < 60) send_cell_word();
    else begin
      if (roll < 85) op = OP_POP_RECT;
      else if (roll < 93) op = OP_CLEAR_MAP;
      else if (roll < 97) op = op_t'(OP_SPARE_LO);
      else op = op_t'(OP_SPARE_HI);
      send_word(op, COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), COORD_W'($urandom));
    end
  endtask

  // Mostly: mark a few rectangles, then pop them back out; else plain noise
  task automatic run_burst();
    int n_rect;
    if ($urandom_range(0, 99) < 80) begin
      n_rect = $urandom_range(1, 4);
      repeat (n_rect) send_rect();
      repeat ($urandom_range(0, 3)) send_cell_word();
      repeat ($urandom_range(2, 3 * n_rect + 2)) begin
        send_word(OP_POP_RECT, COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom));
        if ($urandom_range(0, 3) == 0) send_cell_word();
      end
    end else begin
      repeat (4) send_random_word();
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_grid(int c, int r);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_COLS;
    cfg_data  <= CFG_DATA_W'(c);
    @(negedge clk);
    cfg_index <= CFG_GRID_ROWS;
    cfg_data  <= CFG_DATA_W'(r);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    grid_c = (c > MAX_GRID) ? MAX_GRID : c;
    grid_r = (r > MAX_GRID) ? MAX_GRID : r;
  endtask

  // Response side: random stalls, plus one long hold on request
  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      int gap;
      if (long_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          rsp_ch.ready <= 1'b1;
          @(negedge clk);
        end else begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[dirty_cell_map_rect_extract_core] ERROR");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_GRID_COLS;
    cfg_data         = '0;
    req_ch.valid     = 1'b0;
    req_ch.op        = OP_MARK_RECT;
    req_ch.first_col = '0;
    req_ch.first_row = '0;
    req_ch.end_col   = '0;
    req_ch.end_row   = '0;
    steady           = 1'b0;
    long_hold        = 1'b0;
    items_sent       = 0;
    grid_c           = MAX_GRID;
    grid_r           = MAX_GRID;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words on the reset grid of 64 by 64
    send_word(OP_POP_RECT, 0, 0, 0, 0);             // empty map
    send_word(OP_MARK_RECT, 0, 0, 64, 64);          // whole grid
    send_word(OP_POP_RECT, 0, 0, 0, 0);
    send_word(OP_POP_RECT, 0, 0, 0, 0);
    send_word(OP_MARK_RECT, 62, 62, 127, 127);      // clipped at both ends
    send_word(OP_MARK_RECT, 10, 10, 5, 20);         // inverted columns
    send_word(OP_MARK_RECT, 20, 20, 20, 25);        // zero width
    send_word(OP_MARK_CELL, 0, 63, 0, 0);
    send_word(OP_MARK_CELL, 64, 0, 0, 0);           // off the grid
    send_word(OP_QUERY_CELL, 127, 127, 0, 0);
    send_word(OP_QUERY_CELL, 0, 63, 0, 0);
    send_word(OP_QUERY_CELL, 63, 63, 0, 0);
    send_word(OP_UNMARK_CELL, 63, 63, 0, 0);
    send_word(OP_QUERY_CELL, 63, 63, 0, 0);
    send_word(OP_MARK_RECT, 2, 10, 6, 13);
    send_word(OP_MARK_CELL, 1, 11, 0, 0);           // left neighbor stops the descent
    send_word(OP_POP_RECT, 0, 0, 0, 0);
    send_word(OP_POP_RECT, 0, 0, 0, 0);
    send_word(OP_POP_RECT, 0, 0, 0, 0);
    send_word(op_t'(OP_SPARE_LO), 5, 5, 9, 9);
    send_word(op_t'(OP_SPARE_HI), 127, 127, 127, 127);
    send_word(OP_CLEAR_MAP, 0, 0, 0, 0);
    send_word(OP_POP_RECT, 0, 0, 0, 0);
    send_word(OP_QUERY_CELL, 0, 0, 0, 0);

    // Random phases over a range of grid sizes
    for (int p = 0; p < N_PHASES; p++) begin
      set_grid(phase_cols[p], phase_rows[p]);
      steady = (p % 4 == 3);
      if (p == 5) long_hold = 1'b1;
      items_sent = 0;
      while (items_sent < phase_items[p]) run_burst();
    end

    // Drain and let any stray result show up
    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("[dirty_cell_map_rect_extract_core] OK");
    else
      $display("[dirty_cell_map_rect_extract_core] ERROR");
    $finish;
  end

endmodule
